// File: hw/rtl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types, codes and constants of the vending credit and change block.
// ----------------------------------------------------------------------------
package vcc_pkg;

    localparam int COIN_KINDS   = 6;
    localparam int CREDIT_W     = 16;
    localparam int PRICE_W      = 10;
    localparam int COIN_W       = 8;
    localparam int DRINK_W      = 3;
    localparam int COUNT_W      = 9;
    localparam int NUM_PRICES   = 4;
    localparam int PRICE_IDX_W  = 2;

    // Reciprocal of 200 scaled by 2**23, rounded down.
    localparam int DIV200_MULT  = 41943;
    localparam int DIV200_SHIFT = 23;

    typedef logic [2:0] step_t;
    localparam step_t LAST_STEP = step_t'(COIN_KINDS - 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SELECT = 2'd1,
        ACT_CHANGE = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED      = 3'd0,
        ST_COIN_REJECTED = 3'd1,
        ST_CREDIT_FULL   = 3'd2,
        ST_INVALID_DRINK = 3'd3,
        ST_INSUFFICIENT  = 3'd4,
        ST_CHANGE        = 3'd5
    } status_t;

    typedef struct packed {
        logic [COIN_W-1:0]   coin;
        logic [COUNT_W-1:0]  count;
        logic [CREDIT_W-1:0] remainder;
    } change_t;

    function automatic logic [COIN_W-1:0] denom(input step_t step);
        logic [COIN_W-1:0] d;
        case (step)
            3'd0:    d = 8'd200;
            3'd1:    d = 8'd100;
            3'd2:    d = 8'd50;
            3'd3:    d = 8'd20;
            3'd4:    d = 8'd10;
            3'd5:    d = 8'd5;
            default: d = 8'd5;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/vending_credit_and_change.sv
// ----------------------------------------------------------------------------
// vending_credit_and_change
// Vending credit keeper with coin insertion, drink selection and greedy change.
// ----------------------------------------------------------------------------
// Input beats carry an action on s_axis_tuser and the coin value and drink
// number on s_axis_tdata. Each result beat carries a status on m_axis_tuser,
// the credit, change coin and change count on m_axis_tdata, and tlast on the
// final result of an input beat.
// An accepted beat enters a holding register and its result is then written
// to the output register. Coin and select beats may come back to back while
// the output is not stalled. A change beat holds the stage for six results,
// one result a cycle while the receiver is ready, from 200 down to 5 cents,
// as one greedy step runs per cycle while the receiver is ready. Action
// three is consumed with no result.
// Prices are to be written on the cfg port only while the block is idle; the block itself does not enforce this.
// Reset clears the credit, loads the default prices and empties both stages.
// When the receiver stalls, the result waits in the output register, input
// beats are taken into the holding register until one other than action
// three is held, and then s_axis_tready falls until the output moves.
// ----------------------------------------------------------------------------
module vending_credit_and_change #(
    parameter int MAX_CREDIT = 65535
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vcc_pkg::PRICE_IDX_W-1:0] cfg_index,
    input  logic [vcc_pkg::PRICE_W-1:0]   cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: coin_value[7:0], drink_number[10:8], zero fill.
    input  logic [15:0]                   s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: credit_left[15:0], change_coin[23:16],
    // change_count[32:24], zero fill.
    output logic [39:0]                   m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import vcc_pkg::*;

    logic [PRICE_W-1:0]  price_reg [NUM_PRICES];
    logic [CREDIT_W-1:0] credit_reg, credit_next;

    logic                hold_valid_reg;
    action_t             hold_action_reg;
    logic [COIN_W-1:0]   hold_coin_reg;
    logic [DRINK_W-1:0]  hold_drink_reg;
    step_t               step_reg;

    logic                out_valid_reg;
    status_t             out_status_reg, out_status_next;
    logic [CREDIT_W-1:0] out_credit_reg;
    logic [COIN_W-1:0]   out_coin_reg, out_coin_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    logic                fire;
    logic                item_done;
    logic                in_accept;
    logic                coin_legal;
    logic [CREDIT_W:0]   coin_sum;
    logic [PRICE_W-1:0]  price;
    change_t             change;

    vcc_change_unit u_change (
        .credit (credit_reg),
        .step   (step_reg),
        .result (change)
    );

    assign fire      = hold_valid_reg && (hold_action_reg != ACT_NONE)
                       && (!out_valid_reg || m_axis_tready);
    assign item_done = (hold_valid_reg && (hold_action_reg == ACT_NONE))
                       || (fire && ((hold_action_reg != ACT_CHANGE)
                                    || (step_reg == LAST_STEP)));
    assign s_axis_tready = !hold_valid_reg || item_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        coin_legal = hold_coin_reg inside {8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200};
        coin_sum   = {1'b0, credit_reg} + (CREDIT_W+1)'(hold_coin_reg);
        price      = price_reg[PRICE_IDX_W'(hold_drink_reg - DRINK_W'(1))];
    end

    always_comb
    begin
        credit_next     = credit_reg;
        out_status_next = ST_ACCEPTED;
        out_coin_next   = '0;
        out_count_next  = '0;
        out_last_next   = 1'b1;
        case (hold_action_reg)
            ACT_INSERT:
            begin
                if (!coin_legal)
                begin
                    out_status_next = ST_COIN_REJECTED;
                end
                else if (coin_sum > (CREDIT_W+1)'(MAX_CREDIT))
                begin
                    out_status_next = ST_CREDIT_FULL;
                end
                else
                begin
                    credit_next = coin_sum[CREDIT_W-1:0];
                end
            end
            ACT_SELECT:
            begin
                if (!(hold_drink_reg inside {[3'd1:3'd4]}))
                begin
                    out_status_next = ST_INVALID_DRINK;
                end
                else if (credit_reg >= CREDIT_W'(price))
                begin
                    credit_next = credit_reg - CREDIT_W'(price);
                end
                else
                begin
                    out_status_next = ST_INSUFFICIENT;
                end
            end
            ACT_CHANGE:
            begin
                out_status_next = ST_CHANGE;
                credit_next     = change.remainder;
                out_coin_next   = change.coin;
                out_count_next  = change.count;
                out_last_next   = (step_reg == LAST_STEP);
            end
            default:
            begin
                out_last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_reg[0] <= PRICE_W'(25);
            price_reg[1] <= PRICE_W'(30);
            price_reg[2] <= PRICE_W'(35);
            price_reg[3] <= PRICE_W'(20);
        end
        else if (cfg_we)
        begin
            price_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg     <= '0;
            hold_valid_reg <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                credit_reg <= credit_next;
            end
            if (in_accept)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (item_done)
            begin
                step_reg <= '0;
            end
            else if (fire)
            begin
                step_reg <= step_reg + step_t'(1);
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_action_reg <= action_t'(s_axis_tuser);
            hold_coin_reg   <= s_axis_tdata[7:0];
            hold_drink_reg  <= s_axis_tdata[10:8];
        end
        if (fire)
        begin
            out_status_reg <= out_status_next;
            out_credit_reg <= credit_next;
            out_coin_reg   <= out_coin_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_count_reg, out_coin_reg, out_credit_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_step_only_in_change: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != step_t'(0)) |-> (hold_valid_reg && (hold_action_reg == ACT_CHANGE)))
        else $error("change step counter running outside a change item");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (hold_action_reg != ACT_CHANGE)) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("coin or select result not marked last");

    a_change_leaves_small: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast && (m_axis_tuser == ST_CHANGE))
        |-> (m_axis_tdata[15:0] < 16'd5))
        else $error("change run left five cents or more");
`endif

endmodule

// File: hw/rtl/vcc_change_unit.sv
// ----------------------------------------------------------------------------
// vcc_change_unit
// One greedy change step: coin count and remainder for one denomination.
// ----------------------------------------------------------------------------
module vcc_change_unit (
    input  logic [vcc_pkg::CREDIT_W-1:0] credit,
    input  vcc_pkg::step_t               step,
    output vcc_pkg::change_t             result
);
    import vcc_pkg::*;

    logic [2*CREDIT_W-1:0] product;
    logic [COUNT_W-1:0]    q_raw;
    logic [CREDIT_W:0]     q_times;
    logic [CREDIT_W:0]     rem_raw;
    logic [COUNT_W-1:0]    q_big;
    logic [CREDIT_W-1:0]   rem_big;
    logic [COIN_W-1:0]     d;
    logic [CREDIT_W-1:0]   d_wide;
    logic [CREDIT_W-1:0]   d_twice;
    logic [COUNT_W-1:0]    q_small;
    logic [CREDIT_W-1:0]   rem_small;

    // The first step divides the full credit by 200 with a reciprocal that
    // is never too large, so one correction finishes the quotient.
    always_comb
    begin
        product = credit * CREDIT_W'(DIV200_MULT);
        q_raw   = product[DIV200_SHIFT +: COUNT_W];
        q_times = {1'b0, q_raw, 7'b0} + {2'b0, q_raw, 6'b0} + {5'b0, q_raw, 3'b0};
        rem_raw = {1'b0, credit} - q_times;
        if (rem_raw >= (CREDIT_W+1)'(200))
        begin
            q_big   = q_raw + COUNT_W'(1);
            rem_big = CREDIT_W'(rem_raw - (CREDIT_W+1)'(200));
        end
        else
        begin
            q_big   = q_raw;
            rem_big = rem_raw[CREDIT_W-1:0];
        end
    end

    // Later steps see a remainder below 2.5 times their coin.
    always_comb
    begin
        d       = denom(step);
        d_wide  = CREDIT_W'(d);
        d_twice = CREDIT_W'({d, 1'b0});
        if (credit >= d_twice)
        begin
            q_small   = COUNT_W'(2);
            rem_small = credit - d_twice;
        end
        else if (credit >= d_wide)
        begin
            q_small   = COUNT_W'(1);
            rem_small = credit - d_wide;
        end
        else
        begin
            q_small   = '0;
            rem_small = credit;
        end
    end

    always_comb
    begin
        result.coin = d;
        if (step == step_t'(0))
        begin
            result.count     = q_big;
            result.remainder = rem_big;
        end
        else
        begin
            result.count     = q_small;
            result.remainder = rem_small;
        end
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vending credit and change block.
// A directed table covers reset prices, bad coins, bad drinks and change at
// zero credit. Random beats follow under several price settings, with bursty
// input and a stalling output. Every output beat is compared field by field
// with its table entry or with a running model of the credit.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vcc_pkg::*;

    localparam int unsigned FULL_CREDIT = 65535;

    typedef struct packed {
        action_t    act;
        logic [7:0] coin;
        logic [2:0] drink;
    } beat_t;

    typedef struct packed {
        status_t     st;
        logic [15:0] left;
        logic [7:0]  coin;
        logic [8:0]  count;
        logic        last;
    } receipt_t;

    typedef struct packed {
        beat_t    beat;
        logic     typed;
        receipt_t want;
    } row_t;

    localparam receipt_t NO_RECEIPT = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    receipt_t    due_receipts[$];
    int unsigned credit_now;
    int unsigned price_now[4];
    int unsigned pay_coins[6] = '{200, 100, 50, 20, 10, 5};
    int unsigned fail_count = 0;
    int unsigned burst_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;
    receipt_t    seen;
    receipt_t    want;

    row_t steps[22] = '{
        '{'{ACT_SELECT, 8'd0,   3'd1}, 1'b1, '{ST_INSUFFICIENT,  16'd0, 8'd0, 9'd0, 1'b1}},
        '{'{ACT_INSERT, 8'd0,   3'd0}, 1'b1, '{ST_COIN_REJECTED, 16'd0, 8'd0, 9'd0, 1'b1}},
        '{'{ACT_INSERT, 8'd255, 3'd7}, 1'b1, '{ST_COIN_REJECTED, 16'd0, 8'd0, 9'd0, 1'b1}},
        '{'{ACT_INSERT, 8'd7,   3'd2}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd255, 3'd0}, 1'b1, '{ST_INVALID_DRINK, 16'd0, 8'd0, 9'd0, 1'b1}},
        '{'{ACT_SELECT, 8'd0,   3'd7}, 1'b1, '{ST_INVALID_DRINK, 16'd0, 8'd0, 9'd0, 1'b1}},
        '{'{ACT_SELECT, 8'd0,   3'd5}, 1'b0, NO_RECEIPT},
        '{'{ACT_CHANGE, 8'd0,   3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_INSERT, 8'd5,   3'd7}, 1'b1, '{ST_ACCEPTED,      16'd5, 8'd0, 9'd0, 1'b1}},
        '{'{ACT_INSERT, 8'd10,  3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_INSERT, 8'd20,  3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_INSERT, 8'd50,  3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_INSERT, 8'd100, 3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_INSERT, 8'd200, 3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_NONE,   8'd255, 3'd7}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd0,   3'd1}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd0,   3'd2}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd0,   3'd3}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd0,   3'd4}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd0,   3'd6}, 1'b0, NO_RECEIPT},
        '{'{ACT_CHANGE, 8'd0,   3'd0}, 1'b0, NO_RECEIPT},
        '{'{ACT_SELECT, 8'd0,   3'd4}, 1'b1, '{ST_INSUFFICIENT,  16'd0, 8'd0, 9'd0, 1'b1}}
    };

    vending_credit_and_change dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    task automatic predict_receipts(input beat_t b);
        receipt_t    r;
        int unsigned n;
        r = '0;
        r.last = 1'b1;
        case (b.act)
            ACT_INSERT:
            begin
                if (!(b.coin inside {8'd5, 8'd10, 8'd20, 8'd50, 8'd100, 8'd200}))
                    r.st = ST_COIN_REJECTED;
                else if (credit_now + b.coin > FULL_CREDIT)
                    r.st = ST_CREDIT_FULL;
                else
                begin
                    credit_now += b.coin;
                    r.st = ST_ACCEPTED;
                end
                r.left = credit_now[15:0];
                due_receipts.push_back(r);
            end
            ACT_SELECT:
            begin
                if (b.drink < 3'd1 || b.drink > 3'd4)
                    r.st = ST_INVALID_DRINK;
                else if (credit_now >= price_now[b.drink - 3'd1])
                begin
                    credit_now -= price_now[b.drink - 3'd1];
                    r.st = ST_ACCEPTED;
                end
                else
                    r.st = ST_INSUFFICIENT;
                r.left = credit_now[15:0];
                due_receipts.push_back(r);
            end
            ACT_CHANGE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    n = credit_now / pay_coins[i];
                    credit_now -= n * pay_coins[i];
                    r.st = ST_CHANGE;
                    r.left = credit_now[15:0];
                    r.coin = pay_coins[i][7:0];
                    r.count = n[8:0];
                    r.last = (i == 5);
                    due_receipts.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_beat(input beat_t b, input logic typed, input receipt_t exp_r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, b.drink, b.coin};
        s_axis_tuser <= b.act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_receipts(b);
        if (typed)
            due_receipts[due_receipts.size() - 1] = exp_r;
        @(negedge clk);
    endtask

    task automatic pace();
        int unsigned idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (idle != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (idle) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    function automatic beat_t random_beat();
        beat_t       b;
        int unsigned r;
        r = $urandom_range(0, 99);
        b.coin = 8'($urandom_range(0, 255));
        b.drink = 3'($urandom_range(0, 7));
        if (r < 45)
        begin
            b.act = ACT_INSERT;
            b.coin = pay_coins[$urandom_range(0, 5)][7:0];
        end
        else if (r < 55)
            b.act = ACT_INSERT;
        else if (r < 80)
        begin
            b.act = ACT_SELECT;
            b.drink = 3'($urandom_range(1, 4));
        end
        else if (r < 86)
            b.act = ACT_SELECT;
        else if (r < 95)
            b.act = ACT_CHANGE;
        else
            b.act = ACT_NONE;
        return b;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_receipts.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 80);
        end
        else
            rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_tick % 4 != 0);
            default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
                    m_axis_tdata[32:24], m_axis_tlast};
            if (due_receipts.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got status %0d credit %0d",
                         $time, seen.st, seen.left);
                fail_count++;
            end
            else
            begin
                want = due_receipts.pop_front();
                check_field("status", want.st, seen.st);
                check_field("credit_left", want.left, seen.left);
                check_field("change_coin", want.coin, seen.coin);
                check_field("change_count", want.count, seen.count);
                check_field("last", want.last, seen.last);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned price_sets[4][4];
        int unsigned made;
        beat_t       b;

        credit_now = 0;
        price_now = '{25, 30, 35, 20};
        price_sets[0] = '{0, 0, 1023, 1};
        price_sets[1] = '{1023, 1000, 0, 3};
        for (int i = 0; i < 4; i++)
        begin
            price_sets[2][i] = $urandom_range(0, 1023);
            price_sets[3][i] = $urandom_range(0, 60);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (steps[i])
        begin
            pace();
            send_beat(steps[i].beat, steps[i].typed, steps[i].want);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            for (int idx = 0; idx < 4; idx++)
            begin
                cfg_we <= 1'b1;
                cfg_index <= idx[1:0];
                cfg_data <= price_sets[phase][idx][9:0];
                price_now[idx] = price_sets[phase][idx];
                @(negedge clk);
            end
            cfg_we <= 1'b0;
            made = 0;
            while (made < 47)
            begin
                b = random_beat();
                pace();
                send_beat(b, 1'b0, NO_RECEIPT);
                if (b.act != ACT_NONE)
                    made++;
            end
        end

        s_axis_tvalid <= 1'b0;
        for (int k = 0; k < 20000 && due_receipts.size() != 0; k++)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (due_receipts.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived, expected status %0d, got none",
                     $time, due_receipts.size(), due_receipts[0].st);
            fail_count++;
        end
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
